/* rtl/ssq_pkg.sv */
// shared types, sizes and codes of the stable sorted priority queue
`timescale 1ns / 1ps
package ssq_pkg;

   localparam int CAPACITY = 16;
   localparam int CNT_W    = $clog2(CAPACITY + 1);

   localparam logic [1:0] ACT_PUSH      = 2'd0;
   localparam logic [1:0] ACT_POP       = 2'd1;
   localparam logic [1:0] ACT_PEEK_HIGH = 2'd2;
   localparam logic [1:0] ACT_PEEK_LOW  = 2'd3;

   localparam logic [1:0] ST_DONE  = 2'd0;
   localparam logic [1:0] ST_EMPTY = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;

   typedef struct packed {
      logic [1:0]         action;
      logic signed [31:0] item_value;
      logic signed [31:0] item_priority;
   } req_type;

   typedef struct packed {
      logic signed [31:0] out_value;
      logic signed [31:0] out_priority;
      logic [1:0]         status;
      logic [4:0]         occupancy;
   } rsp_type;

   typedef struct packed {
      logic signed [31:0] value;
      logic signed [31:0] prio;
   } entry_type;

   typedef struct packed {
      logic      push;
      logic      pop;
      entry_type ins;
   } ctl_type;

endpackage

/* rtl/ssq_cell.sv */
// one slot of the sorted shift-register queue
`timescale 1ns / 1ps
module ssq_cell (
   input  logic               clock,
   input  ssq_pkg::ctl_type   ctl,
   input  logic               own_valid,
   input  logic               prev_keep,
   input  ssq_pkg::entry_type prev_entry,
   input  ssq_pkg::entry_type next_entry,
   output ssq_pkg::entry_type entry,
   output logic               keep
);
   import ssq_pkg::*;

   entry_type entry_ff;
   entry_type entry_in;

   assign keep  = own_valid && !($signed(entry_ff.prio) < $signed(ctl.ins.prio));
   assign entry = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      if (ctl.push) begin
         if (keep) begin
            entry_in = entry_ff;
         end else if (prev_keep) begin
            entry_in = ctl.ins;
         end else begin
            entry_in = prev_entry;
         end
      end else if (ctl.pop) begin
         entry_in = next_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

/* rtl/stable_sorted_priority_queue_unit.sv */
// top level of the stable sorted priority queue: cell row, count and response register
// the response word is strobed in the cycle after start is accepted
// throughput: one word per cycle; every cell compares and shifts in the same cycle
// busy is held low, the row finishes each operation in the accepting cycle
// reset: synchronous, clears the entry count and the response strobe; slot data is not cleared
// the receiver cannot stall, each response is on the ports for exactly one cycle
`timescale 1ns / 1ps
module stable_sorted_priority_queue_unit (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  ssq_pkg::req_type req_data,
   output logic             rsp_valid,
   output ssq_pkg::rsp_type rsp_data
);
   import ssq_pkg::*;

   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic             rsp_valid_ff;
   rsp_type          rsp_ff;
   rsp_type          rsp_in;

   ctl_type          ctl;
   entry_type        entries [CAPACITY];
   logic             keeps   [CAPACITY];
   logic             valids  [CAPACITY];
   entry_type        tail_entry;
   logic             accept;
   logic             is_full;
   logic             is_empty;

   assign busy     = 1'b0;
   assign accept   = start && !busy;
   assign is_full  = (count_ff == CNT_W'(CAPACITY));
   assign is_empty = (count_ff == '0);

   always_comb begin
      ctl.push = accept && (req_data.action == ACT_PUSH) && !is_full;
      ctl.pop  = accept && (req_data.action == ACT_POP) && !is_empty;
      ctl.ins.value = req_data.item_value;
      ctl.ins.prio  = req_data.item_priority;
   end

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      assign valids[i] = (count_ff > CNT_W'(i));
      if (i == 0) begin : g_head
         ssq_cell u_cell (
            .clock      (clock),
            .ctl        (ctl),
            .own_valid  (valids[i]),
            .prev_keep  (1'b1),
            .prev_entry ('0),
            .next_entry ((CAPACITY > 1) ? entries[(i + 1) % CAPACITY] : '0),
            .entry      (entries[i]),
            .keep       (keeps[i])
         );
      end else if (i == CAPACITY - 1) begin : g_last
         ssq_cell u_cell (
            .clock      (clock),
            .ctl        (ctl),
            .own_valid  (valids[i]),
            .prev_keep  (keeps[i - 1]),
            .prev_entry (entries[i - 1]),
            .next_entry ('0),
            .entry      (entries[i]),
            .keep       (keeps[i])
         );
      end else begin : g_mid
         ssq_cell u_cell (
            .clock      (clock),
            .ctl        (ctl),
            .own_valid  (valids[i]),
            .prev_keep  (keeps[i - 1]),
            .prev_entry (entries[i - 1]),
            .next_entry (entries[i + 1]),
            .entry      (entries[i]),
            .keep       (keeps[i])
         );
      end
   end

   // tail is the valid cell whose right neighbor is empty
   always_comb begin
      tail_entry = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         if (valids[i] && ((i == CAPACITY - 1) || !valids[(i + 1) % CAPACITY])) begin
            tail_entry = tail_entry | entries[i];
         end
      end
   end

   always_comb begin
      count_in = count_ff;
      if (ctl.push) begin
         count_in = count_ff + 1'b1;
      end else if (ctl.pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_comb begin
      rsp_in              = '0;
      rsp_in.occupancy    = 5'(count_in);
      unique case (req_data.action)
         ACT_PUSH: begin
            rsp_in.status = is_full ? ST_FULL : ST_DONE;
         end
         ACT_POP, ACT_PEEK_HIGH: begin
            if (is_empty) begin
               rsp_in.status = ST_EMPTY;
            end else begin
               rsp_in.out_value    = entries[0].value;
               rsp_in.out_priority = entries[0].prio;
            end
         end
         ACT_PEEK_LOW: begin
            if (is_empty) begin
               rsp_in.status = ST_EMPTY;
            end else begin
               rsp_in.out_value    = tail_entry.value;
               rsp_in.out_priority = tail_entry.prio;
            end
         end
         default: begin
            rsp_in.status = ST_DONE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= accept;
      end
      if (accept) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_strobe_follows_start: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid)
      else $error("response strobe missing after accepted start");

   a_no_spurious_strobe: assert property (@(posedge clock) disable iff (reset)
      !accept |=> !rsp_valid)
      else $error("response strobe without accepted start");

   a_push_counts_up: assert property (@(posedge clock) disable iff (reset)
      ctl.push |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("push did not grow the queue by one");

   a_full_reports_capacity: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.status == ST_FULL)) |-> (rsp_data.occupancy == 5'(CAPACITY)))
      else $error("full status with occupancy below capacity");

   a_empty_zero_payload: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.status == ST_EMPTY))
         |-> ((rsp_data.out_value == '0) && (rsp_data.out_priority == '0)
              && (rsp_data.occupancy == '0)))
      else $error("empty status with nonzero payload");

endmodule
